@@ rtl/rorws_pkg.sv @@
// ----------------------------------------------------------------------------
// rorws_pkg
// Shared constants for the rate-of-rise window sum block: command, status and
// register codes, fixed field widths and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package rorws_pkg;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int SI_W      = 16;
    localparam int WIN_W     = 7;
    localparam int IV_W      = 16;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 16;
    localparam int FRAC_BITS = 8;

    // Default parameter values
    localparam int DEF_HISTORY_DEPTH = 64;
    localparam int DEF_TEMP_WIDTH    = 16;

    // Fraction dividend: |delta| * remainder, shifted up by the fraction bits
    localparam int DEF_DIVIDEND_W = DEF_TEMP_WIDTH + 1 + IV_W + FRAC_BITS;

    // Register reset values
    localparam logic [SI_W-1:0]  SI_RESET  = 16'd1;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LATEST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_WINDOW = 2'd2;

    // Configuration register indexes
    localparam logic REG_SAMPLE_INTERVAL = 1'b0;
    localparam logic REG_WINDOW_SAMPLES  = 1'b1;

endpackage

`default_nettype wire

@@ rtl/rorws_div.sv @@
// ----------------------------------------------------------------------------
// rorws_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// consumed from its top bit, so a short dividend placed in the upper bits
// needs only as many steps as it has bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rorws_div
    import rorws_pkg::*;
#(
    parameter int DIVIDEND_W = DEF_DIVIDEND_W,
    localparam int SCW = $clog2(DIVIDEND_W + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [SI_W-1:0]       divisor,
    input  logic [SCW-1:0]        steps,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [SI_W-1:0]       remainder
);

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [SI_W-1:0]       rem_reg;
    logic [SI_W-1:0]       dsr_reg;
    logic [SCW-1:0]        cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SI_W:0] trial;
    logic [SI_W:0] diff;
    logic          fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                rem_reg <= fits ? diff[SI_W-1:0] : trial[SI_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SCW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/rate_of_rise_window_sum.sv @@
// ----------------------------------------------------------------------------
// rate_of_rise_window_sum
// Temperature rate-of-rise tracker. A sample command stores the difference
// from the previous temperature in a circular history memory; an interval
// query sums the newest deltas covering the interval, plus the next older
// delta scaled by the leftover fraction of a sample, with 8 fraction bits
// truncated toward zero and saturated to 32 bits. A latest query returns the
// newest delta and a clear command empties the history. Items are handled one
// at a time. An interval query reads the deltas that it sums one per cycle,
// newest first; the shared bit-serial divider splits the interval over its 16
// interval bits and works the fractional term over the TEMP_WIDTH + 25 bits
// of the shifted product.
// The history memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_of_rise_window_sum
    import rorws_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int TEMP_WIDTH    = DEF_TEMP_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CMD_W-1:0]             cmd,
    input  logic signed [TEMP_WIDTH-1:0] temperature,
    input  logic [IV_W-1:0]              interval,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VAL_W-1:0]      rise_value,
    output logic [STAT_W-1:0]            status
);

    localparam int TW   = TEMP_WIDTH;
    localparam int DW   = TW + 1;
    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUMW = DW + CW;
    localparam int TOTW_RAW = SUMW + FRAC_BITS + 1;
    localparam int TOTW = (TOTW_RAW > VAL_W + 1) ? TOTW_RAW : VAL_W + 1;
    localparam int PW   = DW + IV_W;
    localparam int DVW  = PW + FRAC_BITS;
    localparam int QW   = TW + FRAC_BITS + 1;
    localparam int SCW  = $clog2(DVW + 1);

    localparam logic signed [TOTW-1:0] SAT_HI = TOTW'(64'sd2147483647);
    localparam logic signed [TOTW-1:0] SAT_LO = TOTW'(-64'sd2147483648);
    localparam logic signed [VAL_W-1:0] VAL_HI = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_LO = 32'sh8000_0000;

    // State codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIVQ     = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_LATEST   = 4'd3;
    localparam logic [3:0] S_FRAC_RD  = 4'd4;
    localparam logic [3:0] S_FRAC_MUL = 4'd5;
    localparam logic [3:0] S_FRAC_GO  = 4'd6;
    localparam logic [3:0] S_DIVF     = 4'd7;
    localparam logic [3:0] S_ADJ      = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    // Registers and next values
    logic [3:0]              state_reg, state_next;
    logic [SI_W-1:0]         si_reg, si_next;
    logic [WIN_W-1:0]        win_reg, win_next;
    logic [CW-1:0]           ec_reg, ec_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic signed [TW-1:0]    prev_reg, prev_next;
    logic [SI_W-1:0]         r_reg, r_next;
    logic                    frac_ok_reg, frac_ok_next;
    logic [AW-1:0]           walk_addr_reg, walk_addr_next;
    logic [CW-1:0]           walk_left_reg, walk_left_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic signed [SUMW-1:0]  sum_reg, sum_next;
    logic                    frac_neg_reg, frac_neg_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic signed [TOTW-1:0]  total_reg, total_next;
    logic                    adj_up_reg, adj_up_next;
    logic                    adj_dn_reg, adj_dn_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] rise_value_reg, rise_value_next;
    logic [STAT_W-1:0]       status_reg, status_next;

    // History memory
    logic signed [DW-1:0] mem [HISTORY_DEPTH];
    logic signed [DW-1:0] mem_rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic signed [DW-1:0] mem_wdata;

    // Divider
    logic             div_start;
    logic [DVW-1:0]   div_dividend;
    logic [SCW-1:0]   div_steps;
    logic             div_done;
    logic [DVW-1:0]   div_quo;
    logic [SI_W-1:0]  div_rem;

    // Combinational helpers
    logic                   in_accept;
    logic [SI_W-1:0]        si_eff;
    logic [CW-1:0]          eff_win;
    logic [CW-1:0]          eff_cnt;
    logic [AW-1:0]          newest;
    logic [AW-1:0]          walk_prev;
    logic signed [DW-1:0]   delta;
    logic [IV_W-1:0]        q_val;
    logic                   q_lt_cnt;
    logic [CW-1:0]          n_val;
    logic [DW-1:0]          mag;
    logic signed [TOTW-1:0] sum_ext;
    logic signed [TOTW-1:0] lat_ext;
    logic signed [TOTW-1:0] fq;
    logic signed [TOTW-1:0] adj_total;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);

    // Effective divisor, window and entry count
    always_comb
    begin
        si_eff = (si_reg == '0) ? SI_W'(1) : si_reg;
        if (win_reg == '0)
        begin
            eff_win = CW'(1);
        end
        else if (32'(win_reg) > 32'(HISTORY_DEPTH))
        begin
            eff_win = CW'(HISTORY_DEPTH);
        end
        else
        begin
            eff_win = CW'(win_reg);
        end
        eff_cnt = (ec_reg < eff_win) ? ec_reg : eff_win;
    end

    // Address and value helpers
    always_comb
    begin
        newest    = (wp_reg == '0) ? AW'(HISTORY_DEPTH - 1) : wp_reg - 1'b1;
        walk_prev = (walk_addr_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                          : walk_addr_reg - 1'b1;
        delta     = DW'(temperature) - DW'(prev_reg);
        q_val     = div_quo[IV_W-1:0];
        q_lt_cnt  = (32'(q_val) < 32'(eff_cnt));
        n_val     = q_lt_cnt ? CW'(q_val) : eff_cnt;
        mag       = mem_rdata_reg[DW-1] ? (~mem_rdata_reg + 1'b1) : mem_rdata_reg;
        sum_ext   = TOTW'(sum_reg);
        lat_ext   = TOTW'(mem_rdata_reg);
        fq        = TOTW'(div_quo[QW-1:0]);
    end

    // Round the total toward zero when the fraction left a remainder
    always_comb
    begin
        adj_total = total_reg;
        if (adj_up_reg && total_reg[TOTW-1])
        begin
            adj_total = total_reg + TOTW'(1);
        end
        else if (adj_dn_reg && (total_reg > TOTW'(0)))
        begin
            adj_total = total_reg - TOTW'(1);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        si_next         = si_reg;
        win_next        = win_reg;
        ec_next         = ec_reg;
        wp_next         = wp_reg;
        prev_next       = prev_reg;
        r_next          = r_reg;
        frac_ok_next    = frac_ok_reg;
        walk_addr_next  = walk_addr_reg;
        walk_left_next  = walk_left_reg;
        rd_pend_next    = 1'b0;
        sum_next        = sum_reg;
        frac_neg_next   = frac_neg_reg;
        prod_next       = prod_reg;
        total_next      = total_reg;
        adj_up_next     = adj_up_reg;
        adj_dn_next     = adj_dn_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = wp_reg;
        mem_raddr       = walk_addr_reg;
        mem_wdata       = delta;
        div_start       = 1'b0;
        div_dividend    = {prod_reg, {FRAC_BITS{1'b0}}};
        div_steps       = SCW'(DVW);

        // Drop the output once it is transferred
        out_valid_next  = out_valid_reg && out_stall;
        rise_value_next = rise_value_reg;
        status_next     = status_reg;

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_INTERVAL: si_next  = cfg_data[SI_W-1:0];
                REG_WINDOW_SAMPLES:  win_next = cfg_data[WIN_W-1:0];
                default:             si_next  = si_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    unique case (cmd)
                        CMD_SAMPLE:
                        begin
                            mem_we     = 1'b1;
                            wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                            : wp_reg + 1'b1;
                            prev_next  = temperature;
                            ec_next    = (ec_reg < eff_win) ? ec_reg + 1'b1 : eff_win;
                            state_next = S_OUT;
                        end
                        CMD_QUERY:
                        begin
                            div_start    = 1'b1;
                            div_dividend = {interval, {(DVW - IV_W){1'b0}}};
                            div_steps    = SCW'(IV_W);
                            state_next   = S_DIVQ;
                        end
                        CMD_LATEST:
                        begin
                            if (eff_cnt == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = newest;
                                state_next = S_LATEST;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ec_next    = '0;
                            wp_next    = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_DIVQ:
            begin
                // Interval split into whole samples and remainder
                if (div_done)
                begin
                    r_next         = div_rem;
                    frac_ok_next   = q_lt_cnt && (div_rem != '0);
                    walk_addr_next = newest;
                    walk_left_next = n_val;
                    sum_next       = '0;
                    if (32'(q_val) > 32'(eff_win))
                    begin
                        res_status_next = STAT_WINDOW;
                        state_next      = S_OUT;
                    end
                    else if (eff_cnt == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // Issue one read per cycle, newest first, and accumulate
                if (walk_left_reg != '0)
                begin
                    mem_re         = 1'b1;
                    rd_pend_next   = 1'b1;
                    walk_addr_next = walk_prev;
                    walk_left_next = walk_left_reg - 1'b1;
                end
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + SUMW'(mem_rdata_reg);
                end
                if ((walk_left_reg == '0) && !rd_pend_reg)
                begin
                    total_next  = sum_ext <<< FRAC_BITS;
                    adj_up_next = 1'b0;
                    adj_dn_next = 1'b0;
                    state_next  = frac_ok_reg ? S_FRAC_RD : S_ADJ;
                end
            end

            S_LATEST:
            begin
                total_next  = lat_ext <<< FRAC_BITS;
                adj_up_next = 1'b0;
                adj_dn_next = 1'b0;
                state_next  = S_ADJ;
            end

            S_FRAC_RD:
            begin
                // Walk address now points at the next older entry
                mem_re     = 1'b1;
                state_next = S_FRAC_MUL;
            end

            S_FRAC_MUL:
            begin
                frac_neg_next = mem_rdata_reg[DW-1];
                prod_next     = PW'(mag) * PW'(r_reg);
                state_next    = S_FRAC_GO;
            end

            S_FRAC_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVF;
            end

            S_DIVF:
            begin
                if (div_done)
                begin
                    total_next  = frac_neg_reg ? total_reg - fq : total_reg + fq;
                    adj_up_next = (div_rem != '0) && !frac_neg_reg;
                    adj_dn_next = (div_rem != '0) && frac_neg_reg;
                    state_next  = S_ADJ;
                end
            end

            S_ADJ:
            begin
                // Saturate to the signed 32-bit range
                if (adj_total > SAT_HI)
                begin
                    res_value_next = VAL_HI;
                end
                else if (adj_total < SAT_LO)
                begin
                    res_value_next = VAL_LO;
                end
                else
                begin
                    res_value_next = adj_total[VAL_W-1:0];
                end
                res_status_next = STAT_OK;
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    rise_value_next = res_value_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            si_reg         <= SI_RESET;
            win_reg        <= WIN_RESET;
            ec_reg         <= '0;
            wp_reg         <= '0;
            prev_reg       <= '0;
            r_reg          <= '0;
            frac_ok_reg    <= 1'b0;
            walk_addr_reg  <= '0;
            walk_left_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            sum_reg        <= '0;
            frac_neg_reg   <= 1'b0;
            prod_reg       <= '0;
            total_reg      <= '0;
            adj_up_reg     <= 1'b0;
            adj_dn_reg     <= 1'b0;
            res_value_reg  <= '0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
            rise_value_reg <= '0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            si_reg         <= si_next;
            win_reg        <= win_next;
            ec_reg         <= ec_next;
            wp_reg         <= wp_next;
            prev_reg       <= prev_next;
            r_reg          <= r_next;
            frac_ok_reg    <= frac_ok_next;
            walk_addr_reg  <= walk_addr_next;
            walk_left_reg  <= walk_left_next;
            rd_pend_reg    <= rd_pend_next;
            sum_reg        <= sum_next;
            frac_neg_reg   <= frac_neg_next;
            prod_reg       <= prod_next;
            total_reg      <= total_next;
            adj_up_reg     <= adj_up_next;
            adj_dn_reg     <= adj_dn_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            rise_value_reg <= rise_value_next;
            status_reg     <= status_next;
        end
    end

    // History memory with a registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Shared divider for the interval split and the fractional term
    rorws_div #(
        .DIVIDEND_W (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (si_eff),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_valid  = out_valid_reg;
    assign rise_value = rise_value_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    // Entry count never exceeds the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ec_reg) <= HISTORY_DEPTH)
        else $error("entry count beyond history depth");

    // Write pointer stays inside the memory
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < HISTORY_DEPTH)
        else $error("write pointer outside history");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVQ || state_reg == S_DIVF))
        else $error("divider result with no waiting query");

    // A new result appears only from the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid && out_stall)) |-> $past(state_reg == S_OUT))
        else $error("result presented outside the output state");
`endif

endmodule

`default_nettype wire
